// ----- src/fcsr_pkg.sv -----
// Shared types, widths, register codes and reset values for the force contact
// seek regulator. No dependencies; every other source file depends on this package.
package fcsr_pkg;

  localparam int unsigned ForceWidth   = 16;              // signed Q8.8 force
  localparam int unsigned FracExt      = 16;              // extra filter fraction bits
  localparam int unsigned FiltWidth    = ForceWidth + FracExt;
  localparam int unsigned CoefWidth    = 16;              // Q0.16 alpha and gain
  localparam int unsigned StepWidth    = ForceWidth - 1;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = (ForceWidth > CoefWidth) ? ForceWidth : CoefWidth;

  typedef logic signed [ForceWidth-1:0] force_t;
  typedef logic signed [FiltWidth-1:0]  filt_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegFilterAlpha   = 3'd0,
    RegRampStep      = 3'd1,
    RegTargetForce   = 3'd2,
    RegContactThresh = 3'd3,
    RegNormalGain    = 3'd4,
    RegClampUpper    = 3'd5,
    RegClampLower    = 3'd6,
    RegSlideLateral  = 3'd7
  } cfg_reg_e;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef enum logic [1:0] {
    PhApproach = 2'b01,
    PhSlide    = 2'b10
  } phase_e;

  typedef struct packed {
    logic [CoefWidth-1:0] alpha;
    logic [StepWidth-1:0] ramp_step;
    force_t               target;
    force_t               threshold;
    logic [CoefWidth-1:0] gain;
    force_t               clamp_upper;
    force_t               clamp_lower;
    force_t               lateral;
  } cfg_t;

  typedef struct packed {
    force_t normal;
    force_t lateral;
    logic   slide;
  } res_t;

  localparam cfg_t CfgReset = '{
    alpha:       CoefWidth'(5243),
    ramp_step:   StepWidth'(10),
    target:      ForceWidth'(-2560),
    threshold:   ForceWidth'(-2304),
    gain:        CoefWidth'(19661),
    clamp_upper: ForceWidth'(-1280),
    clamp_lower: ForceWidth'(-6400),
    lateral:     ForceWidth'(12800)
  };

endpackage

// ----- src/fcsr_filter.sv -----
// Exponential moving average of the measured normal force, kept in Q8.24.
// Depends on fcsr_pkg.
module fcsr_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_i,
  input  fcsr_pkg::force_t                sample_i,
  input  logic [fcsr_pkg::CoefWidth-1:0]  alpha_i,
  output fcsr_pkg::filt_t                 filt_o,
  output logic                            seen_o
);
  import fcsr_pkg::*;

  filt_t                             filt_q, filt_d;
  logic                              seen_q;
  logic signed [FiltWidth:0]         diff;
  logic signed [FiltWidth+CoefWidth+1:0] prod;
  logic signed [FiltWidth:0]         sum;

  // f += floor(alpha * (s*2^16 - f) / 2^16)
  always_comb begin
    diff   = $signed({sample_i[ForceWidth-1], sample_i, {FracExt{1'b0}}})
           - $signed({filt_q[FiltWidth-1], filt_q});
    prod   = diff * $signed({1'b0, alpha_i});
    sum    = $signed({filt_q[FiltWidth-1], filt_q}) + prod[FiltWidth+CoefWidth:CoefWidth];
    filt_d = sum[FiltWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      seen_q <= 1'b0;
    end else if (upd_i) begin
      filt_q <= filt_d;
      seen_q <= 1'b1;
    end
  end

  assign filt_o = filt_q;
  assign seen_o = seen_q;

endmodule

// ----- src/fcsr_law.sv -----
// Approach ramp, contact detection and clamped proportional slide law.
// Depends on fcsr_pkg.
module fcsr_law (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  fcsr_pkg::filt_t filt_i,
  input  fcsr_pkg::cfg_t  cfg_i,
  output fcsr_pkg::res_t  res_o
);
  import fcsr_pkg::*;

  phase_e                                phase_q;
  force_t                                ramped_q;
  force_t                                ramp_next;
  logic signed [ForceWidth:0]            ramp_sub;
  logic                                  contact;
  logic signed [FiltWidth:0]             err;
  logic signed [FiltWidth+CoefWidth+1:0] prod;
  logic signed [ForceWidth+2:0]          cmd;
  force_t                                slide_cmd;

  // Approach: step down toward target, saturating at it
  always_comb begin
    ramp_sub = $signed({ramped_q[ForceWidth-1], ramped_q}) - $signed({2'b00, cfg_i.ramp_step});
    if (ramped_q > cfg_i.target) begin
      if (ramp_sub < $signed({cfg_i.target[ForceWidth-1], cfg_i.target})) begin
        ramp_next = cfg_i.target;
      end else begin
        ramp_next = ramp_sub[ForceWidth-1:0];
      end
    end else begin
      ramp_next = ramped_q;
    end
    contact = filt_i < $signed({cfg_i.threshold, {FracExt{1'b0}}});
  end

  // Slide: target + floor(gain * (target*2^16 - f) / 2^32), upper then lower clamp
  always_comb begin
    err  = $signed({cfg_i.target[ForceWidth-1], cfg_i.target, {FracExt{1'b0}}})
         - $signed({filt_i[FiltWidth-1], filt_i});
    prod = err * $signed({1'b0, cfg_i.gain});
    cmd  = $signed({{3{cfg_i.target[ForceWidth-1]}}, cfg_i.target})
         + $signed({prod[FiltWidth+CoefWidth+1], prod[FiltWidth+CoefWidth+1:CoefWidth+FracExt]});
    slide_cmd = cmd[ForceWidth-1:0];
    if (cmd > $signed({{3{cfg_i.clamp_upper[ForceWidth-1]}}, cfg_i.clamp_upper})) begin
      slide_cmd = cfg_i.clamp_upper;
    end
    if (cmd < $signed({{3{cfg_i.clamp_lower[ForceWidth-1]}}, cfg_i.clamp_lower}) ||
        (cmd > $signed({{3{cfg_i.clamp_upper[ForceWidth-1]}}, cfg_i.clamp_upper}) &&
         cfg_i.clamp_upper < cfg_i.clamp_lower)) begin
      slide_cmd = cfg_i.clamp_lower;
    end
  end

  always_comb begin
    case (phase_q)
      PhSlide: begin
        res_o = '{normal: slide_cmd, lateral: cfg_i.lateral, slide: 1'b1};
      end
      default: begin
        res_o = '{normal: ramp_next, lateral: '0, slide: 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhApproach;
      ramped_q <= '0;
    end else if (tick_i && phase_q != PhSlide) begin
      if (contact) begin
        ramped_q <= cfg_i.target;
        phase_q  <= PhSlide;
      end else begin
        ramped_q <= ramp_next;
      end
    end
  end

endmodule

// ----- src/force_contact_seek_regulator.sv -----
// Top level of the force contact seek regulator: configuration registers,
// input register, result register. Depends on fcsr_pkg, fcsr_filter, fcsr_law.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o   | command_i, force_sample_i
//  out     | out_valid_o / out_ready_i | normal_force_cmd_o, lateral_force_cmd_o,
//          |                           | phase_out_o
//  cfg     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// An accepted item is evaluated from the input register in a single pass (one
// 33x17 multiply, add and clamp) and lands in the result register at the next edge.
// Items pass the input then the result register; one per cycle unless output stalls.
// Samples give no result; ticks before the first sample give none and change nothing.
// Reset clears filter, phase, ramp and control state and loads register defaults.
// An output stall holds the input register; one more item is taken while stalled.
module force_contact_seek_regulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  fcsr_pkg::force_t                    force_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fcsr_pkg::force_t                    normal_force_cmd_o,
  output fcsr_pkg::force_t                    lateral_force_cmd_o,
  output logic                                phase_out_o,
  input  logic                                cfg_we_i,
  input  logic [fcsr_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [fcsr_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import fcsr_pkg::*;

  cfg_t   cfg_q;
  logic   in_valid_q;
  logic   cmd_q;
  force_t sample_q;
  logic   out_valid_q;
  res_t   out_q;

  logic   advance;
  logic   in_xfer;
  logic   upd;
  logic   tick;
  logic   seen;
  filt_t  filt;
  res_t   res;

  // Configuration writes: no wait; keep the block idle around them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFilterAlpha:   cfg_q.alpha       <= cfg_data_i[CoefWidth-1:0];
        RegRampStep:      cfg_q.ramp_step   <= cfg_data_i[StepWidth-1:0];
        RegTargetForce:   cfg_q.target      <= cfg_data_i[ForceWidth-1:0];
        RegContactThresh: cfg_q.threshold   <= cfg_data_i[ForceWidth-1:0];
        RegNormalGain:    cfg_q.gain        <= cfg_data_i[CoefWidth-1:0];
        RegClampUpper:    cfg_q.clamp_upper <= cfg_data_i[ForceWidth-1:0];
        RegClampLower:    cfg_q.clamp_lower <= cfg_data_i[ForceWidth-1:0];
        RegSlideLateral:  cfg_q.lateral     <= cfg_data_i[ForceWidth-1:0];
        default: ;
      endcase
    end
  end

  // Evaluate the held item whenever the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign upd  = advance && (cmd_q == CmdSample);
  assign tick = advance && (cmd_q == CmdTick) && seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload holds until the next transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      sample_q <= force_sample_i;
    end
  end

  fcsr_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .sample_i (sample_q),
    .alpha_i  (cfg_q.alpha),
    .filt_o   (filt),
    .seen_o   (seen)
  );

  fcsr_law u_law (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .filt_i (filt),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register: drop on transfer, load on every tick that yields a command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign normal_force_cmd_o  = out_q.normal;
  assign lateral_force_cmd_o = out_q.lateral;
  assign phase_out_o         = out_q.slide;

endmodule

// ----- src/fcsr_checker.sv -----
// Port-level checks for force_contact_seek_regulator, attached by bind.
// Depends on fcsr_pkg and the top level's port list.
module fcsr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input fcsr_pkg::force_t                    normal_force_cmd_o,
  input fcsr_pkg::force_t                    lateral_force_cmd_o,
  input logic                                phase_out_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_force_cmd_o)
      && $stable(lateral_force_cmd_o) && $stable(phase_out_o))
    else $error("stalled result changed");

  // A free result register never blocks the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  // A fresh result needs a matching earlier input transfer
  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

  // Approach commands carry no lateral force
  a_approach_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !phase_out_o |-> lateral_force_cmd_o == '0)
    else $error("lateral force in approach");

  // Slide never returns to approach
  a_phase_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_out_o |=> !(out_valid_o && !phase_out_o))
    else $error("approach result after slide");

endmodule

bind force_contact_seek_regulator fcsr_checker u_fcsr_checker (.*);

// ----- tb/sv/fcsr_cmd_checker.sv -----
// Command checker for the force contact seek regulator: follows the input,
// output and register-write ports, predicts each force command and compares.
// Depends on fcsr_pkg for the force, configuration and result types.
`timescale 1ns / 100ps

module fcsr_cmd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              command_i,
  input  fcsr_pkg::force_t                  sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  fcsr_pkg::force_t                  normal_i,
  input  fcsr_pkg::force_t                  lateral_i,
  input  logic                              phase_i,
  input  logic                              cfg_we_i,
  input  logic [fcsr_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [fcsr_pkg::CfgDataWidth-1:0] cfg_data_i,
  output int                                mismatches_o,
  output int                                awaiting_o
);
  import fcsr_pkg::*;

  cfg_t   regs;
  longint filt_acc;      // filtered normal force, Q8.24
  bit     sample_seen;
  longint ramp_acc;      // ramped approach command, Q8.8
  phase_e contact_phase;
  res_t   expected_cmds[$];

  task automatic apply_write(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
    case (cfg_reg_e'(idx))
      RegFilterAlpha:   regs.alpha       = data[CoefWidth-1:0];
      RegRampStep:      regs.ramp_step   = data[StepWidth-1:0];
      RegTargetForce:   regs.target      = data[ForceWidth-1:0];
      RegContactThresh: regs.threshold   = data[ForceWidth-1:0];
      RegNormalGain:    regs.gain        = data[CoefWidth-1:0];
      RegClampUpper:    regs.clamp_upper = data[ForceWidth-1:0];
      RegClampLower:    regs.clamp_lower = data[ForceWidth-1:0];
      RegSlideLateral:  regs.lateral     = data[ForceWidth-1:0];
      default: ;
    endcase
  endtask

  // Advance the predicted regulator by one item; queue a command for ticks.
  task automatic advance_regulator(input logic cmd, input force_t sample);
    longint target;
    longint diff;
    longint err;
    longint normal;
    longint upper;
    longint lower;
    res_t   r;
    target = longint'($signed(regs.target));
    if (cmd == CmdSample) begin
      diff        = longint'($signed(sample)) * 65536 - filt_acc;
      filt_acc    = filt_acc + ((diff * longint'(regs.alpha)) >>> 16);
      sample_seen = 1'b1;
    end else if (sample_seen) begin
      if (contact_phase == PhApproach) begin
        // ramp downward only, saturating at the target
        if (ramp_acc > target) begin
          ramp_acc = ramp_acc - longint'(regs.ramp_step);
          if (ramp_acc < target) ramp_acc = target;
        end
        r.normal  = force_t'(ramp_acc);
        r.lateral = '0;
        r.slide   = 1'b0;
        // contact is reported by the following tick, not this one
        if (filt_acc < longint'($signed(regs.threshold)) * 65536) begin
          ramp_acc      = target;
          contact_phase = PhSlide;
        end
      end else begin
        err    = target * 65536 - filt_acc;
        normal = target + ((err * longint'(regs.gain)) >>> 32);
        upper  = longint'($signed(regs.clamp_upper));
        lower  = longint'($signed(regs.clamp_lower));
        if (normal > upper) normal = upper;
        if (normal < lower) normal = lower;   // lower wins when limits cross
        r.normal  = force_t'(normal);
        r.lateral = regs.lateral;
        r.slide   = 1'b1;
      end
      expected_cmds.push_back(r);
    end
  endtask

  task automatic compare_cmd();
    res_t got;
    res_t want;
    got = '{normal: normal_i, lateral: lateral_i, slide: phase_i};
    if (expected_cmds.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("%0t: unexpected command normal=%0d lateral=%0d phase=%0b",
                 $realtime, got.normal, got.lateral, got.slide);
    end else begin
      want = expected_cmds.pop_front();
      if (got.normal !== want.normal || got.lateral !== want.lateral ||
          got.slide !== want.slide) begin
        mismatches_o++;
        if (mismatches_o <= 10)
          $display("%0t: mismatch: exp n=%0d l=%0d p=%0b, got n=%0d l=%0d p=%0b",
                   $realtime, want.normal, want.lateral, want.slide,
                   got.normal, got.lateral, got.slide);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      regs          = CfgReset;
      filt_acc      = 0;
      sample_seen   = 1'b0;
      ramp_acc      = 0;
      contact_phase = PhApproach;
      expected_cmds.delete();
      mismatches_o  = 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (out_valid_i && out_ready_i) compare_cmd();
      if (in_valid_i && in_ready_i) advance_regulator(command_i, sample_i);
    end
    awaiting_o = expected_cmds.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the force contact seek regulator: clock, reset, stimulus,
// output back-pressure, watchdog and verdict. Depends on fcsr_pkg, the block
// force_contact_seek_regulator and the command checker fcsr_cmd_checker.
`timescale 1ns / 100ps

module tb;
  import fcsr_pkg::*;

  localparam int StallLimit = 3000;   // cycles without any transfer
  localparam int HoldCycles = 300;    // long receiver hold-off

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic                    command;
  force_t                  force_sample;
  logic                    out_valid;
  logic                    out_ready;
  force_t                  normal_cmd;
  force_t                  lateral_cmd;
  logic                    phase_out;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  int mismatches;
  int awaiting;
  int tx_idle;      // percent of cycles the sender idles
  int rx_idle;      // percent of cycles the receiver idles
  bit hold_go;      // raised by the stimulus, consumed by the receiver
  bit hold_done;

  force_contact_seek_regulator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (command),
    .force_sample_i     (force_sample),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .normal_force_cmd_o (normal_cmd),
    .lateral_force_cmd_o(lateral_cmd),
    .phase_out_o        (phase_out),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  fcsr_cmd_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .command_i   (command),
    .sample_i    (force_sample),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .normal_i    (normal_cmd),
    .lateral_i   (lateral_cmd),
    .phase_i     (phase_out),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .awaiting_o  (awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item from a falling edge; idle beforehand at random, then hold
  // valid and payload until the transfer happens at a rising edge.
  task automatic put_item(input logic cmd, input force_t sample);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    force_sample <= sample;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Draw a force: half the time close to a centre value, else full range or extremes.
  function automatic force_t pick_force(input force_t centre);
    int v;
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      v = int'(centre) + int'($urandom_range(3000)) - 1500;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return force_t'(v);
    end
    if (r < 80) return force_t'($urandom);
    case ($urandom_range(3))
      0:       return force_t'(32767);
      1:       return force_t'(-32768);
      2:       return force_t'(0);
      default: return force_t'(-1);
    endcase
  endfunction

  // Random mix of samples and ticks; the sample field on ticks is noise.
  task automatic put_random(input int n, input force_t centre);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1) == 0) put_item(CmdSample, pick_force(centre));
      else                        put_item(CmdTick, force_t'($urandom));
    end
  endtask

  // Drop valid and wait until every command has come, then let any sample
  // still in the pipeline settle before registers change.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Write all eight registers back to back, then release the write enable.
  task automatic load_config(input cfg_t c);
    write_reg(RegFilterAlpha,   CfgDataWidth'(c.alpha));
    write_reg(RegRampStep,      CfgDataWidth'(c.ramp_step));
    write_reg(RegTargetForce,   CfgDataWidth'(c.target));
    write_reg(RegContactThresh, CfgDataWidth'(c.threshold));
    write_reg(RegNormalGain,    CfgDataWidth'(c.gain));
    write_reg(RegClampUpper,    CfgDataWidth'(c.clamp_upper));
    write_reg(RegClampLower,    CfgDataWidth'(c.clamp_lower));
    write_reg(RegSlideLateral,  CfgDataWidth'(c.lateral));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.alpha       = CoefWidth'($urandom);
    c.ramp_step   = StepWidth'($urandom);
    c.target      = force_t'($urandom);
    c.threshold   = force_t'($urandom);
    c.gain        = CoefWidth'($urandom);
    c.clamp_upper = force_t'($urandom);
    c.clamp_lower = force_t'($urandom);
    c.lateral     = force_t'($urandom);
    return c;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d commands outstanding",
             StallLimit, awaiting);
    $display("** force_contact_seek_regulator: FAILED **");
    $finish;
  end

  initial begin
    cfg_t c;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    command      = CmdSample;
    force_sample = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_idle      = 31;
    rx_idle      = 31;
    hold_go      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings: ticks before any sample give nothing, then
    // approach commands around sample extremes without reaching contact.
    put_item(CmdTick, force_t'(0));
    put_item(CmdTick, force_t'(-1));
    put_item(CmdSample, force_t'(0));
    put_item(CmdTick, force_t'(0));
    put_item(CmdSample, force_t'(32767));
    put_item(CmdTick, force_t'(0));
    put_item(CmdSample, force_t'(-1));
    put_item(CmdTick, force_t'(0));

    // Approach phases: threshold at its minimum, so contact cannot happen.
    // Zero ramp step with full alpha: the command stays where it is.
    drain();
    c             = random_cfg();
    c.threshold   = force_t'(-32768);
    c.alpha       = CoefWidth'(65535);
    c.ramp_step   = '0;
    c.target      = force_t'(-20000);
    load_config(c);
    put_random(150, force_t'(0));

    // Frozen filter, small steps; a stretch without any idling on either side.
    drain();
    tx_idle     = 0;
    rx_idle     = 0;
    c.alpha     = '0;
    c.ramp_step = StepWidth'($urandom_range(300, 1));
    load_config(c);
    put_random(150, force_t'(0));
    tx_idle = 31;
    rx_idle = 31;

    // Random target: a target above the ramp leaves it unmoved.
    drain();
    c.alpha     = CoefWidth'($urandom);
    c.ramp_step = StepWidth'($urandom_range(3000, 1));
    c.target    = force_t'(-30000 + int'($urandom_range(20000)));
    load_config(c);
    put_random(150, force_t'(0));

    // Largest step towards the lowest target: saturate at the target.
    drain();
    c.ramp_step = StepWidth'(32767);
    c.target    = force_t'(-32768);
    load_config(c);
    put_random(60, force_t'(0));

    // Directed contact: a full-weight minimum sample crosses the threshold;
    // that tick still reports approach, the next one slides.
    drain();
    c           = CfgReset;
    c.alpha     = CoefWidth'(65535);
    load_config(c);
    put_item(CmdSample, force_t'(-32768));
    put_item(CmdTick, force_t'(0));
    put_item(CmdTick, force_t'(0));
    put_item(CmdSample, force_t'(32767));
    put_item(CmdTick, force_t'(0));

    // Slide at reset settings; hold the receiver off for a long stretch while
    // items keep coming, so the block fills and stalls its input.
    drain();
    load_config(CfgReset);
    hold_go = 1'b1;
    put_random(200, CfgReset.target);

    // Full gain, widest clamps, most negative lateral force.
    drain();
    c             = random_cfg();
    c.gain        = CoefWidth'(65535);
    c.target      = force_t'(0);
    c.clamp_upper = force_t'(32767);
    c.clamp_lower = force_t'(-32768);
    c.lateral     = force_t'(-32768);
    load_config(c);
    put_random(150, c.target);

    // Zero gain and crossed clamps: the lower limit wins.
    drain();
    c             = random_cfg();
    c.gain        = '0;
    c.clamp_lower = force_t'(int'($urandom_range(30000)));
    c.clamp_upper = force_t'(-int'($urandom_range(30000)) - 1);
    c.lateral     = force_t'(32767);
    load_config(c);
    put_random(150, c.target);

    // Fully random settings.
    for (int p = 0; p < 3; p++) begin
      drain();
      c = random_cfg();
      load_config(c);
      put_random(100, c.target);
    end

    // Wait out every outstanding command, let the block settle, then give the verdict.
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && awaiting == 0)
      $display("** force_contact_seek_regulator: PASSED **");
    else
      $display("** force_contact_seek_regulator: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
src/fcsr_pkg.sv
src/fcsr_filter.sv
src/fcsr_law.sv
src/force_contact_seek_regulator.sv
src/fcsr_checker.sv
tb/sv/fcsr_cmd_checker.sv
tb/sv/tb.sv
